>>> src/acrlf_pkg.sv
// Package for the fully associative tag cache with LRU or FIFO replacement.
// Holds register codes, policy codes, field widths and the cell control struct.
// No dependencies.
package acrlf_pkg;

  localparam int MAX_ENTRIES_DEF  = 64;
  localparam int ADDRESS_BITS_DEF = 32;

  localparam int CAP_W   = 7;
  localparam int CNT_W   = 32;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = CFG_IDX_W'(1);

  localparam logic POLICY_LRU  = 1'b0;
  localparam logic POLICY_FIFO = 1'b1;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(64);

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic look;  // compare the incoming address against the stored tag
    logic upd;   // cells up to the shift limit take their neighbor's entry
  } cell_ctl_t;

endpackage

>>> src/acrlf_cell.sv
// One entry of the recency-ordered tag chain: tag, valid bit and match flag.
// Takes its neighbor's entry on a shift; uses acrlf_pkg.
module acrlf_cell #(
  parameter int ADDRESS_BITS = acrlf_pkg::ADDRESS_BITS_DEF,
  parameter int IDX_W        = 6,
  parameter int INDEX        = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  acrlf_pkg::cell_ctl_t    ctl,
  input  logic [IDX_W-1:0]        limit,
  input  logic [ADDRESS_BITS-1:0] address,
  input  logic [ADDRESS_BITS-1:0] tag_in,
  input  logic                    valid_in,
  output logic [ADDRESS_BITS-1:0] tag_out,
  output logic                    valid_out,
  output logic                    match
);

  logic [ADDRESS_BITS-1:0] tag;
  logic                    valid;
  logic                    shift_en;

  // Position 0 holds the newest or most recently used entry; everything at
  // or below the limit moves one place toward the end of the chain.
  assign shift_en = ctl.upd && (IDX_W'(INDEX) <= limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift_en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      tag <= tag_in;
    end
    if (ctl.look) begin
      match <= valid && (tag == address);
    end
  end

  assign tag_out   = tag;
  assign valid_out = valid;

endmodule

>>> src/acrlf_enc.sv
// Encodes the one-hot match vector of the cell chain into a position.
// Stored tags are distinct, so at most one cell matches; uses no package.
module acrlf_enc #(
  parameter int MAX_ENTRIES = 64,
  parameter int IDX_W       = 6
) (
  input  logic [MAX_ENTRIES-1:0] match,
  output logic                   any,
  output logic [IDX_W-1:0]       index
);

  always_comb begin
    index = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      index = index | (match[i] ? IDX_W'(i) : IDX_W'(0));
    end
  end

  assign any = |match;

endmodule

>>> src/assoc_cache_replacement_lru_fifo_core.sv
// Fully associative tag cache, LRU or FIFO replacement, saturating counters.
// A start accepted in ST_IDLE registers the compare in every cell; in ST_UPDATE hit and done are registered.
// A new access is taken only in ST_IDLE; the core is busy in ST_UPDATE, where the
// recency chain shifts after the address compare in every cell.
// Reset: synchronous; all entries invalid, counters zero, LRU, capacity 64.
// The receiver cannot stall; each result is shown for one cycle only.
module assoc_cache_replacement_lru_fifo_core #(
  parameter int MAX_ENTRIES  = acrlf_pkg::MAX_ENTRIES_DEF,
  parameter int ADDRESS_BITS = acrlf_pkg::ADDRESS_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [ADDRESS_BITS-1:0]            access_address,
  output logic                               done,
  output logic                               hit,
  output logic [acrlf_pkg::CNT_W-1:0]        accesses_so_far,
  output logic [acrlf_pkg::CNT_W-1:0]        misses_so_far,
  input  logic                               cfg_we,
  input  logic [acrlf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [acrlf_pkg::CFG_W-1:0]        cfg_data
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = OCC_W + acrlf_pkg::CAP_W;

  acrlf_pkg::state_t    state, state_next;
  acrlf_pkg::cell_ctl_t ctl;

  logic                          policy;
  logic [acrlf_pkg::CAP_W-1:0]   capacity;
  logic [OCC_W-1:0]              occ, occ_next;
  logic [ADDRESS_BITS-1:0]       key;
  logic [acrlf_pkg::CNT_W-1:0]   acc_count, miss_count;

  logic                          accept;
  logic                          found;
  logic [IDX_W-1:0]              found_idx;
  logic [IDX_W-1:0]              limit;
  logic                          room;
  logic [CMP_W-1:0]              cap_ext, eff_cap;

  logic [MAX_ENTRIES-1:0]        match;
  logic [ADDRESS_BITS-1:0]       chain_tag [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]        chain_valid;

  assign accept = start && (state == acrlf_pkg::ST_IDLE);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      acrlf_pkg::ST_IDLE: begin
        if (start) begin
          state_next = acrlf_pkg::ST_UPDATE;
        end
      end
      acrlf_pkg::ST_UPDATE: begin
        state_next = acrlf_pkg::ST_IDLE;
      end
      default: begin
        state_next = acrlf_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    busy     = 1'b0;
    ctl.look = 1'b0;
    ctl.upd  = 1'b0;
    unique case (state)
      acrlf_pkg::ST_IDLE: begin
        ctl.look = start;
      end
      acrlf_pkg::ST_UPDATE: begin
        busy    = 1'b1;
        ctl.upd = !found || (policy == acrlf_pkg::POLICY_LRU);
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= acrlf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capacity clamped to the range one to MAX_ENTRIES.
  always_comb begin
    cap_ext = CMP_W'(capacity);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
      eff_cap = CMP_W'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
    room = CMP_W'(occ) < eff_cap;
  end

  // Under LRU a hit moves the chain up to the matching cell (not under FIFO).
  // A miss with room shifts every valid entry and fills one more cell; a miss
  // without room drops the last occupied cell's entry: the replacement victim.
  always_comb begin
    occ_next = occ;
    if (found) begin
      limit = found_idx;
    end else if (room) begin
      limit    = IDX_W'(occ);
      occ_next = occ + OCC_W'(1);
    end else begin
      limit = IDX_W'(occ - OCC_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy     <= acrlf_pkg::POLICY_LRU;
      capacity   <= acrlf_pkg::CAPACITY_RESET;
      occ        <= '0;
      acc_count  <= '0;
      miss_count <= '0;
      done       <= 1'b0;
    end else begin
      done <= (state == acrlf_pkg::ST_UPDATE);
      if (cfg_we) begin
        if (cfg_index == acrlf_pkg::REG_POLICY) begin
          policy <= cfg_data[0];
        end else if (cfg_index == acrlf_pkg::REG_CAPACITY) begin
          capacity <= cfg_data[acrlf_pkg::CAP_W-1:0];
        end
      end
      if (state == acrlf_pkg::ST_UPDATE) begin
        if (acc_count != '1) begin
          acc_count <= acc_count + acrlf_pkg::CNT_W'(1);
        end
        if (!found) begin
          occ <= occ_next;
          if (miss_count != '1) begin
            miss_count <= miss_count + acrlf_pkg::CNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key <= access_address;
    end
    if (state == acrlf_pkg::ST_UPDATE) begin
      hit <= found;
    end
  end

  assign accesses_so_far = acc_count;
  assign misses_so_far   = miss_count;

  acrlf_enc #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .IDX_W       (IDX_W)
  ) u_enc (
    .match (match),
    .any   (found),
    .index (found_idx)
  );

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [ADDRESS_BITS-1:0] tag_in;
    logic                    valid_in;

    if (i == 0) begin : g_head
      assign tag_in   = key;
      assign valid_in = 1'b1;
    end else begin : g_body
      assign tag_in   = chain_tag[i-1];
      assign valid_in = chain_valid[i-1];
    end

    acrlf_cell #(
      .ADDRESS_BITS (ADDRESS_BITS),
      .IDX_W        (IDX_W),
      .INDEX        (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .limit     (limit),
      .address   (access_address),
      .tag_in    (tag_in),
      .valid_in  (valid_in),
      .tag_out   (chain_tag[i]),
      .valid_out (chain_valid[i]),
      .match     (match[i])
    );
  end

endmodule

>>> test/testbench.sv
// Self-checking testbench for assoc_cache_replacement_lru_fifo_core.
// Tracks LRU/FIFO tag residency and counters in a small class, drives the core directly.
// Depends on acrlf_pkg and the core module only.
`timescale 1ns / 100ps

module testbench;

  localparam int TAG_W       = acrlf_pkg::ADDRESS_BITS_DEF;
  localparam int SLOTS       = acrlf_pkg::MAX_ENTRIES_DEF;
  localparam int POOL_SIZE   = 96;
  localparam int STALL_LIMIT = 200;
  localparam int N_PHASES    = 9;

  // Indexes with no register behind them; writes there must be ignored.
  localparam logic [acrlf_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = acrlf_pkg::CFG_IDX_W'(2);
  localparam logic [acrlf_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = acrlf_pkg::CFG_IDX_W'(3);

  typedef struct {
    logic                        hit;
    logic [acrlf_pkg::CNT_W-1:0] accesses;
    logic [acrlf_pkg::CNT_W-1:0] misses;
  } access_outcome_t;

  class tag_cache_tracker;
    logic                        policy;
    logic [acrlf_pkg::CAP_W-1:0] capacity;
    logic [TAG_W-1:0]            tags[SLOTS];
    bit                          valid[SLOTS];
    int unsigned                 rank[SLOTS];
    int unsigned                 occupancy;
    logic [acrlf_pkg::CNT_W-1:0] n_accesses;
    logic [acrlf_pkg::CNT_W-1:0] n_misses;
    access_outcome_t             pending_outcomes[$];
    int                          errors;

    function new();
      policy     = acrlf_pkg::POLICY_LRU;
      capacity   = acrlf_pkg::CAPACITY_RESET;
      occupancy  = 0;
      n_accesses = '0;
      n_misses   = '0;
      errors     = 0;
      foreach (valid[i]) begin
        valid[i] = 1'b0;
        rank[i]  = 0;
        tags[i]  = '0;
      end
    endfunction

    function void write_register(logic [acrlf_pkg::CFG_IDX_W-1:0] idx,
                                 logic [acrlf_pkg::CFG_W-1:0] data);
      case (idx)
        acrlf_pkg::REG_POLICY:   policy = data[0];
        acrlf_pkg::REG_CAPACITY: capacity = data[acrlf_pkg::CAP_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned usable_slots();
      if (capacity == 0) return 1;
      if (capacity > SLOTS) return SLOTS;
      return capacity;
    endfunction

    function void note_access(logic [TAG_W-1:0] addr);
      int              found;
      int              slot;
      int unsigned     r;
      int unsigned     worst;
      access_outcome_t outcome;
      found = -1;
      slot  = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (found < 0 && valid[i] && tags[i] == addr) found = i;
      end
      if (n_accesses != '1) n_accesses++;
      if (found >= 0) begin
        outcome.hit = 1'b1;
        if (policy == acrlf_pkg::POLICY_LRU) begin
          r = rank[found];
          for (int i = 0; i < SLOTS; i++) begin
            if (valid[i] && rank[i] < r) rank[i]++;
          end
          rank[found] = 0;
        end
      end else begin
        outcome.hit = 1'b0;
        if (n_misses != '1) n_misses++;
        if (occupancy < usable_slots()) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot < 0 && !valid[i]) slot = i;
          end
          if (slot >= 0) occupancy++;
        end
        // No free entry in reach: the highest rank is the victim.
        if (slot < 0) begin
          worst = 0;
          for (int i = 0; i < SLOTS; i++) begin
            if (valid[i] && (slot < 0 || rank[i] > worst)) begin
              worst = rank[i];
              slot  = i;
            end
          end
          if (slot >= 0) valid[slot] = 1'b0;
        end
        if (slot >= 0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (valid[i]) rank[i]++;
          end
          tags[slot]  = addr;
          valid[slot] = 1'b1;
          rank[slot]  = 0;
        end
      end
      outcome.accesses = n_accesses;
      outcome.misses   = n_misses;
      pending_outcomes = {pending_outcomes, outcome};
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic got_hit, logic [acrlf_pkg::CNT_W-1:0] got_acc,
                      logic [acrlf_pkg::CNT_W-1:0] got_miss);
      access_outcome_t want;
      if (pending_outcomes.size() == 0) begin
        report_mismatch($sformatf("result with no transaction pending: hit=%0b acc=%0d miss=%0d",
                                  got_hit, got_acc, got_miss));
        return;
      end
      want = pending_outcomes.pop_front();
      if (got_hit !== want.hit)
        report_mismatch($sformatf("hit got %0b want %0b", got_hit, want.hit));
      if (got_acc !== want.accesses)
        report_mismatch($sformatf("accesses_so_far got %0d want %0d", got_acc, want.accesses));
      if (got_miss !== want.misses)
        report_mismatch($sformatf("misses_so_far got %0d want %0d", got_miss, want.misses));
    endtask
  endclass

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            start;
  logic                            busy;
  logic [TAG_W-1:0]                access_address;
  logic                            done;
  logic                            hit;
  logic [acrlf_pkg::CNT_W-1:0]     accesses_so_far;
  logic [acrlf_pkg::CNT_W-1:0]     misses_so_far;
  logic                            cfg_we;
  logic [acrlf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [acrlf_pkg::CFG_W-1:0]     cfg_data;

  tag_cache_tracker tracker = new();
  int               stall_cycles = 0;
  logic [TAG_W-1:0] addr_pool[POOL_SIZE];

  assoc_cache_replacement_lru_fifo_core dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .access_address(access_address),
    .done(done),
    .hit(hit),
    .accesses_so_far(accesses_so_far),
    .misses_so_far(misses_so_far),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Results are checked before the transaction accepted at the same edge is noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) tracker.check_result(hit, accesses_so_far, misses_so_far);
      if (start && !busy) tracker.note_access(access_address);
    end
    if (rst || done || (start && !busy) || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_access(input logic [TAG_W-1:0] addr, input int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start          <= 1'b1;
    access_address <= addr;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (tracker.pending_outcomes.size() != 0 || busy) @(negedge clk);
  endtask

  // Leaves cfg_we high so that back-to-back writes never toggle it in one step.
  task automatic write_reg(input logic [acrlf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [acrlf_pkg::CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    tracker.write_register(idx, data);
  endtask

  task automatic reconfigure(input logic pol, input logic [acrlf_pkg::CFG_W-1:0] cap);
    drain();
    write_reg(acrlf_pkg::REG_POLICY, acrlf_pkg::CFG_W'(pol));
    write_reg(acrlf_pkg::REG_CAPACITY, cap);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [TAG_W-1:0] pick_address(int ws);
    int k;
    int j;
    k = $urandom_range(ws - 1);
    case ($urandom_range(19))
      0, 1: return $urandom;
      2, 3, 4, 5, 6, 7: begin
        // Skew toward the low end of the working set so recency matters.
        j = $urandom_range(ws - 1);
        return addr_pool[(j < k) ? j : k];
      end
      default: return addr_pool[k];
    endcase
  endfunction

  logic phase_policy[N_PHASES] = '{acrlf_pkg::POLICY_LRU, acrlf_pkg::POLICY_FIFO,
                                   acrlf_pkg::POLICY_LRU, acrlf_pkg::POLICY_FIFO,
                                   acrlf_pkg::POLICY_LRU, acrlf_pkg::POLICY_FIFO,
                                   acrlf_pkg::POLICY_LRU, acrlf_pkg::POLICY_FIFO,
                                   acrlf_pkg::POLICY_LRU};
  logic [acrlf_pkg::CFG_W-1:0] phase_capacity[N_PHASES] = '{7'd4, 7'd9, 7'd17, 7'd33, 7'd127,
                                                            7'd64, 7'd5, 7'd1, 7'd64};
  int               phase_items[N_PHASES] = '{120, 140, 160, 150, 220, 170, 150, 150, 160};
  int               phase_idle[N_PHASES]  = '{38, 38, 38, 58, 58, 58, 0, 0, 0};
  int               phase_ws[N_PHASES]    = '{6, 11, 20, 36, 70, 68, 72, 66, 40};

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    access_address = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    foreach (addr_pool[i]) addr_pool[i] = $urandom;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings, then capacity zero acting as a single entry.
    send_access(32'h0000_0000, 0);
    send_access(32'h0000_0000, 0);
    drain();
    write_reg(REG_SPARE_2, 7'h7F);
    write_reg(REG_SPARE_3, 7'h01);
    write_reg(acrlf_pkg::REG_CAPACITY, 7'd0);
    cfg_we <= 1'b0;
    send_access(32'hFFFF_FFFF, 0);
    send_access(32'h0000_0000, 0);
    send_access(32'h0000_0000, 0);

    // FIFO with two entries: a hit does not save the oldest entry.
    reconfigure(acrlf_pkg::POLICY_FIFO, 7'd2);
    send_access(32'h8000_0000, 0);
    send_access(32'h0000_0000, 0);
    send_access(32'h0000_0001, 0);
    send_access(32'h8000_0000, 0);
    send_access(32'h0000_0000, 0);

    // LRU with three entries: a hit protects the entry from eviction.
    reconfigure(acrlf_pkg::POLICY_LRU, 7'd3);
    send_access(32'h5555_5555, 0);
    send_access(32'h0000_0001, 0);
    send_access(32'hAAAA_AAAA, 0);
    send_access(32'h0000_0000, 0);
    send_access(32'h0000_0001, 0);
    send_access(32'h5555_5555, 0);
    send_access(32'h7FFF_FFFF, 0);
    send_access(32'hFFFF_FFFF, 0);

    // Capacities grow first, since occupancy never shrinks; later phases lower
    // capacity below occupancy and flip the policy on a populated cache.
    for (int p = 0; p < N_PHASES; p++) begin
      reconfigure(phase_policy[p], phase_capacity[p]);
      foreach (addr_pool[i]) begin
        if ($urandom_range(1)) addr_pool[i] = $urandom;
      end
      for (int n = 0; n < phase_items[p]; n++) begin
        send_access(pick_address(phase_ws[p]), phase_idle[p]);
      end
    end

    drain();
    repeat (8) @(negedge clk);
    if (tracker.pending_outcomes.size() != 0)
      tracker.report_mismatch($sformatf("%0d transactions never produced a result",
                                        tracker.pending_outcomes.size()));
    if (tracker.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> assoc_cache_replacement_lru_fifo_core.f
src/acrlf_pkg.sv
src/acrlf_cell.sv
src/acrlf_enc.sv
src/assoc_cache_replacement_lru_fifo_core.sv
test/testbench.sv
